// ===== src/slt_pkg.sv =====
// shared types, codes and keyword table of the lox scanner
package slt_pkg;

	typedef enum logic [7:0] {
		M_IDLE    = 8'b0000_0001,
		M_OPER    = 8'b0000_0010,
		M_COMMENT = 8'b0000_0100,
		M_STRING  = 8'b0000_1000,
		M_INT     = 8'b0001_0000,
		M_DOT     = 8'b0010_0000,
		M_FRAC    = 8'b0100_0000,
		M_IDENT   = 8'b1000_0000
	} mode_t;

	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_BANG    = 3'd1,
		OP_EQUAL   = 3'd2,
		OP_LESS    = 3'd3,
		OP_GREATER = 3'd4,
		OP_SLASH   = 3'd5
	} op_t;

	localparam logic [5:0] K_DOT    = 6'd5;
	localparam logic [5:0] K_BANG   = 6'd10;
	localparam logic [5:0] K_EQUAL  = 6'd12;
	localparam logic [5:0] K_LESS   = 6'd14;
	localparam logic [5:0] K_GREAT  = 6'd16;
	localparam logic [5:0] K_SLASH  = 6'd18;
	localparam logic [5:0] K_STRING = 6'd19;
	localparam logic [5:0] K_NUMBER = 6'd20;
	localparam logic [5:0] K_IDENT  = 6'd21;
	localparam logic [5:0] K_KW0    = 6'd22;
	localparam logic [5:0] K_END    = 6'd38;
	localparam logic [5:0] K_BAD    = 6'd39;
	localparam logic [5:0] K_UNTERM = 6'd40;

	localparam logic [47:0] KW_TEXT [16] = '{
		48'h0000_00646E61, 48'h0073_73616C63, 48'h0000_65736C65, 48'h0065_736C6166,
		48'h0000_00726F66, 48'h0000_006E7566, 48'h0000_00006669, 48'h0000_006C696E,
		48'h0000_0000726F, 48'h0074_6E697270, 48'h6E72_75746572, 48'h0072_65707573,
		48'h0000_73696874, 48'h0000_65757274, 48'h0000_00726176, 48'h0065_6C696877
	};
	localparam logic [2:0] KW_LEN [16] = '{
		3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
		3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
	};

	function automatic logic [5:0] ident_kind(input logic [47:0] buf_v, input logic [2:0] len);
		logic [5:0] k;
		k = K_IDENT;
		for (int i = 0; i < 16; i++) begin
			if (len == KW_LEN[i] && buf_v == KW_TEXT[i])
				k = K_KW0 + 6'(i);
		end
		return k;
	endfunction

	function automatic logic [4:0] punct_code(input logic [7:0] c);
		logic [4:0] r;
		case (c)
			8'h28: r = 5'h10;
			8'h29: r = 5'h11;
			8'h7B: r = 5'h12;
			8'h7D: r = 5'h13;
			8'h2C: r = 5'h14;
			8'h2E: r = 5'h15;
			8'h2D: r = 5'h16;
			8'h2B: r = 5'h17;
			8'h3B: r = 5'h18;
			8'h2A: r = 5'h19;
			default: r = 5'h00;
		endcase
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
	endfunction

endpackage

// ===== src/slt_ifs.sv =====
// byte and token channel interfaces
interface slt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_input;
	modport source(output valid, ch, end_of_input, input ready);
	modport sink(input valid, ch, end_of_input, output ready);
endinterface

interface slt_out_if #(
	parameter int PB = 20,
	parameter int LB = 16
);
	logic          valid;
	logic          ready;
	logic [5:0]    token_kind;
	logic [PB-1:0] start_pos;
	logic [PB-1:0] length;
	logic [LB-1:0] line;
	logic          last;
	modport source(output valid, token_kind, start_pos, length, line, last, input ready);
	modport sink(input valid, token_kind, start_pos, length, line, last, output ready);
endinterface

// ===== src/slt_scan.sv =====
// front end: scans one byte per cycle, unless the group queue is full, into a group of up to three tokens
module slt_scan #(
	parameter int PB = 20,
	parameter int LB = 16,
	parameter int GW = 3 * (6 + 2 * PB + LB) + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	slt_in_if.sink        rx,
	input  logic          full,
	output logic          push,
	output logic [GW-1:0] grp,
	output logic [PB-1:0] cur_pos
);
	typedef struct packed {
		logic [5:0]    kind;
		logic [PB-1:0] start;
		logic [PB-1:0] len;
		logic [LB-1:0] line;
	} tok_t;
	typedef struct packed {
		tok_t [2:0] slot;
		logic [1:0] cnt;
	} grp_t;

	localparam logic [PB-1:0] POS_MAX  = '1;
	localparam logic [LB-1:0] LINE_MAX = '1;

	slt_pkg::mode_t mode_q, mode_d;
	slt_pkg::op_t   op_q, op_d;
	logic [PB-1:0]  pos_q, start_q, start_d;
	logic [LB-1:0]  line_q, line_d;
	logic [47:0]    kw_q, kw_d;
	logic [2:0]     idl_q, idl_d;
	grp_t           g;
	logic           fresh, take;
	logic [7:0]     c;
	logic [PB-1:0]  diff, cm1, dlen, slen;
	logic [4:0]     pc;

	assign rx.ready = !full;
	assign take     = rx.valid && rx.ready;
	assign c        = rx.ch;
	assign cur_pos  = pos_q;
	assign pc       = slt_pkg::punct_code(c);
	assign diff     = (pos_q >= start_q) ? pos_q - start_q : '0;
	assign cm1      = (pos_q != '0) ? pos_q - PB'(1) : '0;
	assign dlen     = (cm1 >= start_q) ? cm1 - start_q : '0;
	assign slen     = (diff == POS_MAX) ? POS_MAX : diff + PB'(1);

	always_comb begin
		g       = '0;
		fresh   = 1'b0;
		mode_d  = mode_q;
		op_d    = op_q;
		start_d = start_q;
		line_d  = line_q;
		kw_d    = kw_q;
		idl_d   = idl_q;
		for (int i = 0; i < 3; i++) g.slot[i].line = line_q;
		if (rx.end_of_input) begin
			unique case (mode_q)
				slt_pkg::M_OPER: begin
					g.slot[g.cnt].kind  = (op_q == slt_pkg::OP_BANG) ? slt_pkg::K_BANG :
						(op_q == slt_pkg::OP_EQUAL) ? slt_pkg::K_EQUAL :
						(op_q == slt_pkg::OP_LESS) ? slt_pkg::K_LESS :
						(op_q == slt_pkg::OP_GREATER) ? slt_pkg::K_GREAT : slt_pkg::K_SLASH;
					g.slot[g.cnt].start = start_q;
					g.slot[g.cnt].len   = PB'(1);
					g.cnt = g.cnt + 2'd1;
				end
				slt_pkg::M_STRING: begin
					g.slot[g.cnt].kind  = slt_pkg::K_UNTERM;
					g.slot[g.cnt].start = start_q;
					g.slot[g.cnt].len   = diff;
					g.cnt = g.cnt + 2'd1;
				end
				slt_pkg::M_INT, slt_pkg::M_FRAC: begin
					g.slot[g.cnt].kind  = slt_pkg::K_NUMBER;
					g.slot[g.cnt].start = start_q;
					g.slot[g.cnt].len   = diff;
					g.cnt = g.cnt + 2'd1;
				end
				slt_pkg::M_DOT: begin
					g.slot[0].kind  = slt_pkg::K_NUMBER;
					g.slot[0].start = start_q;
					g.slot[0].len   = dlen;
					g.slot[1].kind  = slt_pkg::K_DOT;
					g.slot[1].start = cm1;
					g.slot[1].len   = PB'(1);
					g.cnt = 2'd2;
				end
				slt_pkg::M_IDENT: begin
					g.slot[g.cnt].kind  = (idl_q > 3'd6) ? slt_pkg::K_IDENT :
						slt_pkg::ident_kind(kw_q, idl_q);
					g.slot[g.cnt].start = start_q;
					g.slot[g.cnt].len   = diff;
					g.cnt = g.cnt + 2'd1;
				end
				default: ;
			endcase
			g.slot[g.cnt].kind  = slt_pkg::K_END;
			g.slot[g.cnt].start = pos_q;
			g.slot[g.cnt].len   = '0;
			g.cnt   = g.cnt + 2'd1;
			mode_d  = slt_pkg::M_IDLE;
			op_d    = slt_pkg::OP_NONE;
			start_d = '0;
			line_d  = LB'(1);
			kw_d    = '0;
			idl_d   = '0;
		end else begin
			unique case (mode_q)
				slt_pkg::M_OPER: begin
					if (op_q == slt_pkg::OP_SLASH) begin
						if (c == 8'h2F) begin
							mode_d = slt_pkg::M_COMMENT;
							op_d   = slt_pkg::OP_NONE;
						end else begin
							g.slot[0].kind  = slt_pkg::K_SLASH;
							g.slot[0].start = start_q;
							g.slot[0].len   = PB'(1);
							g.cnt = 2'd1;
							fresh = 1'b1;
						end
					end else begin
						g.slot[0].kind  = (op_q == slt_pkg::OP_BANG) ? slt_pkg::K_BANG :
							(op_q == slt_pkg::OP_EQUAL) ? slt_pkg::K_EQUAL :
							(op_q == slt_pkg::OP_LESS) ? slt_pkg::K_LESS : slt_pkg::K_GREAT;
						g.slot[0].start = start_q;
						g.cnt = 2'd1;
						if (c == 8'h3D) begin
							g.slot[0].kind = g.slot[0].kind + 6'd1;
							g.slot[0].len  = PB'(2);
							mode_d = slt_pkg::M_IDLE;
							op_d   = slt_pkg::OP_NONE;
						end else begin
							g.slot[0].len = PB'(1);
							fresh = 1'b1;
						end
					end
				end
				slt_pkg::M_COMMENT: begin
					if (c == 8'h0A) begin
						if (line_q != LINE_MAX) line_d = line_q + LB'(1);
						mode_d = slt_pkg::M_IDLE;
					end
				end
				slt_pkg::M_STRING: begin
					if (c == 8'h22) begin
						g.slot[0].kind  = slt_pkg::K_STRING;
						g.slot[0].start = start_q;
						g.slot[0].len   = slen;
						g.cnt  = 2'd1;
						mode_d = slt_pkg::M_IDLE;
					end else if (c == 8'h0A) begin
						if (line_q != LINE_MAX) line_d = line_q + LB'(1);
					end
				end
				slt_pkg::M_INT, slt_pkg::M_FRAC: begin
					if (c == 8'h2E && mode_q == slt_pkg::M_INT) begin
						mode_d = slt_pkg::M_DOT;
					end else if (!slt_pkg::is_digit(c)) begin
						g.slot[0].kind  = slt_pkg::K_NUMBER;
						g.slot[0].start = start_q;
						g.slot[0].len   = diff;
						g.cnt = 2'd1;
						fresh = 1'b1;
					end
				end
				slt_pkg::M_DOT: begin
					if (slt_pkg::is_digit(c)) begin
						mode_d = slt_pkg::M_FRAC;
					end else begin
						g.slot[0].kind  = slt_pkg::K_NUMBER;
						g.slot[0].start = start_q;
						g.slot[0].len   = dlen;
						g.slot[1].kind  = slt_pkg::K_DOT;
						g.slot[1].start = cm1;
						g.slot[1].len   = PB'(1);
						g.cnt = 2'd2;
						fresh = 1'b1;
					end
				end
				slt_pkg::M_IDENT: begin
					if (slt_pkg::is_alpha(c) || slt_pkg::is_digit(c)) begin
						if (idl_q < 3'd6) begin
							kw_d[idl_q*8 +: 8] = c;
							idl_d = idl_q + 3'd1;
						end else begin
							idl_d = 3'd7;
						end
					end else begin
						g.slot[0].kind  = (idl_q > 3'd6) ? slt_pkg::K_IDENT :
							slt_pkg::ident_kind(kw_q, idl_q);
						g.slot[0].start = start_q;
						g.slot[0].len   = diff;
						g.cnt = 2'd1;
						fresh = 1'b1;
					end
				end
				default: fresh = 1'b1;
			endcase
			if (fresh) begin
				mode_d  = slt_pkg::M_IDLE;
				op_d    = slt_pkg::OP_NONE;
				start_d = pos_q;
				g.slot[g.cnt].start = pos_q;
				g.slot[g.cnt].len   = PB'(1);
				if (pc[4]) begin
					g.slot[g.cnt].kind = 6'(pc[3:0]);
					g.cnt = g.cnt + 2'd1;
				end else begin
					case (c)
						8'h20, 8'h0D, 8'h09: ;
						8'h0A: if (line_q != LINE_MAX) line_d = line_q + LB'(1);
						8'h21: begin mode_d = slt_pkg::M_OPER; op_d = slt_pkg::OP_BANG; end
						8'h3D: begin mode_d = slt_pkg::M_OPER; op_d = slt_pkg::OP_EQUAL; end
						8'h3C: begin mode_d = slt_pkg::M_OPER; op_d = slt_pkg::OP_LESS; end
						8'h3E: begin mode_d = slt_pkg::M_OPER; op_d = slt_pkg::OP_GREATER; end
						8'h2F: begin mode_d = slt_pkg::M_OPER; op_d = slt_pkg::OP_SLASH; end
						8'h22: mode_d = slt_pkg::M_STRING;
						default: begin
							if (slt_pkg::is_digit(c)) begin
								mode_d = slt_pkg::M_INT;
							end else if (slt_pkg::is_alpha(c)) begin
								mode_d = slt_pkg::M_IDENT;
								kw_d   = {40'd0, c};
								idl_d  = 3'd1;
							end else begin
								g.slot[g.cnt].kind = slt_pkg::K_BAD;
								g.cnt = g.cnt + 2'd1;
							end
						end
					endcase
				end
			end
		end
	end

	assign push = take && (g.cnt != 2'd0);
	assign grp  = g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= slt_pkg::M_IDLE;
			op_q    <= slt_pkg::OP_NONE;
			pos_q   <= '0;
			start_q <= '0;
			line_q  <= LB'(1);
			kw_q    <= '0;
			idl_q   <= '0;
		end else if (take) begin
			mode_q  <= mode_d;
			op_q    <= op_d;
			start_q <= start_d;
			line_q  <= line_d;
			kw_q    <= kw_d;
			idl_q   <= idl_d;
			if (rx.end_of_input) pos_q <= '0;
			else if (pos_q != POS_MAX) pos_q <= pos_q + PB'(1);
		end
	end
endmodule

// ===== src/slt_fifo.sv =====
// two-entry queue of token groups between scanner and emitter
module slt_fifo #(
	parameter int GW = 200
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [GW-1:0] wdata,
	input  logic          pop,
	output logic [GW-1:0] rdata,
	output logic          full,
	output logic          empty
);
	logic [GW-1:0] mem [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== src/slt_emit.sv =====
// back end: splits token groups into single output beats
module slt_emit #(
	parameter int PB = 20,
	parameter int LB = 16,
	parameter int GW = 3 * (6 + 2 * PB + LB) + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [GW-1:0] head,
	input  logic          empty,
	output logic          pop,
	slt_out_if.source     tx
);
	typedef struct packed {
		logic [5:0]    kind;
		logic [PB-1:0] start;
		logic [PB-1:0] len;
		logic [LB-1:0] line;
	} tok_t;
	typedef struct packed {
		tok_t [2:0] slot;
		logic [1:0] cnt;
	} grp_t;

	grp_t       grp_q;
	logic       have_q, vld_q, last_q, adv, fin;
	logic [1:0] idx_q;
	tok_t       out_q;

	assign adv = !vld_q || tx.ready;
	assign fin = have_q && adv && (idx_q == grp_q.cnt - 2'd1);
	assign pop = !empty && (!have_q || fin);

	always_ff @(posedge clk) begin
		if (pop) grp_q <= grp_t'(head);
		if (adv && have_q) begin
			out_q  <= grp_q.slot[idx_q];
			last_q <= idx_q == grp_q.cnt - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			vld_q  <= 1'b0;
			idx_q  <= 2'd0;
		end else begin
			if (adv) vld_q <= have_q;
			if (pop) begin
				have_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (fin) begin
				have_q <= 1'b0;
			end else if (adv && have_q) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	assign tx.valid      = vld_q;
	assign tx.token_kind = out_q.kind;
	assign tx.start_pos  = out_q.start;
	assign tx.length     = out_q.len;
	assign tx.line       = out_q.line;
	assign tx.last       = last_q;
endmodule

// ===== src/script_lexer_tokenizer.sv =====
// top level of the lox scanner: scanner, group queue and token emitter
// a token is registered in the group queue, then the emitter's group and output registers
// throughput: one byte per cycle while each byte yields at most one token and tx is ready
// bytes finishing up to three tokens can stall rx; emitter drains one beat per ready cycle
// reset: async, clears mode, position, line (to one), the group queue and the emitter
module script_lexer_tokenizer #(
	parameter int POSITION_BITS = 20,
	parameter int LINE_BITS     = 16
) (
	input logic       clk,
	input logic       arst_n,
	slt_in_if.sink    rx,
	slt_out_if.source tx
);
	localparam int GW = 3 * (6 + 2 * POSITION_BITS + LINE_BITS) + 2;

	logic                     push, pop, full, empty;
	logic [GW-1:0]            wgrp, rgrp;
	logic [POSITION_BITS-1:0] cur_pos;

	slt_scan #(.PB(POSITION_BITS), .LB(LINE_BITS), .GW(GW)) u_scan (
		.clk, .arst_n, .rx, .full, .push, .grp(wgrp), .cur_pos
	);

	slt_fifo #(.GW(GW)) u_fifo (
		.clk, .arst_n, .push, .wdata(wgrp), .pop, .rdata(rgrp), .full, .empty
	);

	slt_emit #(.PB(POSITION_BITS), .LB(LINE_BITS), .GW(GW)) u_emit (
		.clk, .arst_n, .head(rgrp), .empty, .pop, .tx
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("group pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("group popped from empty queue");
	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		rx.valid && rx.ready && rx.end_of_input |=> cur_pos == '0)
		else $error("position not restarted after end of input");
endmodule
